### hdl/block_xor_rotate_hash_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the XOR-rotate block hash
// Shorthand for the clocked implication checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef BLOCK_XOR_ROTATE_HASH_MACROS_SVH
`define BLOCK_XOR_ROTATE_HASH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BXRH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BXRH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bxrh_pkg.sv
// ----------------------------------------------------------------------------
// bxrh_pkg
// Shared types, constants and the byte mixing function of the block hash.
// ----------------------------------------------------------------------------
package bxrh_pkg;

   localparam int unsigned MAX_BLOCK_DEF = 64;
   localparam int unsigned BYTE_W        = 8;
   // Block positions and sizes are bounded by the 64-byte cap.
   localparam int unsigned POS_W         = 6;
   localparam int unsigned SIZE_W        = 7;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam int unsigned CSR_ADDR_W    = 3;

   localparam logic [SIZE_W-1:0] BLK_LEN_RST = SIZE_W'(64);
   localparam logic              REG_BLK_LEN = 1'b0;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // One item travelling down the cell chain.
   typedef struct packed {
      logic              valid;
      logic              finish;
      logic              first;
      logic [POS_W-1:0]  pos;
      logic [BYTE_W-1:0] data;
   } token_type;

   typedef struct packed {
      logic draining;
      logic emitting;
   } status_type;

   function automatic logic [BYTE_W-1:0] mix(input logic [BYTE_W-1:0] h,
                                             input logic [BYTE_W-1:0] p);
      logic [BYTE_W-1:0] rot;
      rot = {h[0], h[BYTE_W-1:1]};
      return h ^ p ^ rot;
   endfunction

endpackage

### hdl/bxrh_cell.sv
// ----------------------------------------------------------------------------
// bxrh_cell
// One digest byte of the hash. Absorbs the item passing by when it targets
// this position and hands the item on to the next cell.
// ----------------------------------------------------------------------------
module bxrh_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bxrh_pkg::SIZE_W-1:0]    size,
   input  bxrh_pkg::token_type            token_in,
   output bxrh_pkg::token_type            token_out,
   input  logic                           shift_en,
   input  logic [bxrh_pkg::BYTE_W-1:0]    shift_in,
   output logic [bxrh_pkg::BYTE_W-1:0]    digest
);
   import bxrh_pkg::*;

   logic [BYTE_W-1:0] digest_ff;
   logic [BYTE_W-1:0] digest_in;
   token_type         token_ff;
   logic              hit_byte;
   logic              hit_pad;
   logic [BYTE_W-1:0] operand;

   // A finish pads every position from the current one up to the block end.
   assign hit_byte = token_in.valid && (token_in.finish == KIND_BYTE) &&
                     (token_in.pos == POS_W'(IDX));
   assign hit_pad  = token_in.valid && (token_in.finish == KIND_FINISH) &&
                     (POS_W'(IDX) >= token_in.pos) && (SIZE_W'(IDX) < size);
   assign operand  = hit_byte ? token_in.data : '0;

   always_comb begin
      digest_in = digest_ff;
      if (shift_en) begin
         digest_in = shift_in;
      end else if (hit_byte || hit_pad) begin
         digest_in = token_in.first ? operand : mix(digest_ff, operand);
      end
   end

   always_ff @(posedge clock) begin
      digest_ff <= digest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in.valid;
      end
      token_ff.finish <= token_in.finish;
      token_ff.first  <= token_in.first;
      token_ff.pos    <= token_in.pos;
      token_ff.data   <= token_in.data;
   end

   assign token_out = token_ff;
   assign digest    = digest_ff;

endmodule

### hdl/bxrh_ctrl.sv
// ----------------------------------------------------------------------------
// bxrh_ctrl
// Block position tracking, item injection into the cell chain and the
// digest read-out sequencer with its output register.
// ----------------------------------------------------------------------------
module bxrh_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [bxrh_pkg::SIZE_W-1:0]    size,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [bxrh_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bxrh_pkg::BYTE_W-1:0]    rsp_hash_byte,
   output logic                           rsp_last,
   output bxrh_pkg::token_type            head_token,
   input  bxrh_pkg::token_type            tail_token,
   input  logic [bxrh_pkg::BYTE_W-1:0]    head_digest,
   output logic                           shift_en,
   output bxrh_pkg::status_type           status
);
   import bxrh_pkg::*;

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  position_ff, position_in;
   logic              first_ff, first_in;
   logic [SIZE_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] hash_ff;
   logic              last_ff;
   logic              accept;
   logic              load;
   logic              final_byte;
   logic [SIZE_W-1:0] pos_next;

   assign req_ready  = (state_ff == ST_RUN);
   assign accept     = req_valid && req_ready;
   assign load       = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (count_ff == size - SIZE_W'(1));
   assign pos_next   = SIZE_W'(position_ff) + SIZE_W'(1);

   always_comb begin
      head_token.valid  = accept;
      head_token.finish = req_kind;
      head_token.first  = first_ff;
      head_token.pos    = position_ff;
      head_token.data   = req_data_byte;
   end

   always_comb begin
      state_in     = state_ff;
      position_in  = position_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (req_kind == KIND_FINISH) begin
                  position_in = '0;
                  first_in    = 1'b1;
                  state_in    = ST_DRAIN;
               end else if (pos_next >= size) begin
                  position_in = '0;
                  first_in    = 1'b0;
               end else begin
                  position_in = pos_next[POS_W-1:0];
               end
            end
         end
         ST_DRAIN: begin
            // The padding is complete once the finish leaves the last cell.
            count_in = '0;
            if (tail_token.valid && (tail_token.finish == KIND_FINISH)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               count_in     = count_ff + SIZE_W'(1);
               if (final_byte) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         position_ff  <= '0;
         first_ff     <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hash_ff <= head_digest;
         last_ff <= final_byte;
      end
   end

   // Each loaded byte shifts the digests one cell toward cell 0 so the next position reaches cell 0.
   assign shift_en        = load;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_byte   = hash_ff;
   assign rsp_last        = last_ff;
   assign status.draining = (state_ff == ST_DRAIN);
   assign status.emitting = (state_ff == ST_EMIT);

endmodule

### hdl/block_xor_rotate_hash.sv
// ----------------------------------------------------------------------------
// block_xor_rotate_hash
// Byte-wise XOR-rotate block hash built as a chain of digest-byte cells.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the input is open and travel
// down a chain of MAX_BLOCK cells, one cell per cycle, each cell holding one
// digest byte and updating it when the passing byte targets its position. A
// finish transfer closes the input while it walks the whole chain to pad the
// block, and then the digest is read out of cell 0 one byte per cycle when
// the result side does not stall, the chain shifting toward cell 0 with each
// byte; the last byte is marked with rsp_last. The next message can start as
// soon as the last digest byte sits in the output register. The block length
// register (address 0, reset value 64) must be written only between
// transfers; values outside 1..MAX_BLOCK act as the nearest bound.
module block_xor_rotate_hash #(
   parameter int unsigned MAX_BLOCK = bxrh_pkg::MAX_BLOCK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [bxrh_pkg::BYTE_W-1:0]        req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bxrh_pkg::BYTE_W-1:0]        rsp_hash_byte,
   output logic                               rsp_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bxrh_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bxrh_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bxrh_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import bxrh_pkg::*;

   logic [SIZE_W-1:0] blk_len_ff, blk_len_in;
   logic [SIZE_W-1:0] size;
   logic              csr_hit;
   logic              shift_en;
   status_type        status;
   token_type         tok_chain [MAX_BLOCK+1];
   logic [BYTE_W-1:0] digest [MAX_BLOCK];

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_BLK_LEN);

   always_comb begin
      blk_len_in = blk_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         blk_len_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_len_ff <= BLK_LEN_RST;
      end else begin
         blk_len_ff <= blk_len_in;
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(blk_len_ff) : '0;

   always_comb begin
      size = blk_len_ff;
      if (blk_len_ff == '0) begin
         size = SIZE_W'(1);
      end else if (blk_len_ff > SIZE_W'(MAX_BLOCK)) begin
         size = SIZE_W'(MAX_BLOCK);
      end
   end

   bxrh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .size          (size),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hash_byte (rsp_hash_byte),
      .rsp_last      (rsp_last),
      .head_token    (tok_chain[0]),
      .tail_token    (tok_chain[MAX_BLOCK]),
      .head_digest   (digest[0]),
      .shift_en      (shift_en),
      .status        (status)
   );

   for (genvar i = 0; i < MAX_BLOCK; i++) begin : g_cell
      logic [BYTE_W-1:0] shift_src;
      if (i == MAX_BLOCK - 1) begin : g_end
         assign shift_src = digest[i];
      end else begin : g_mid
         assign shift_src = digest[i+1];
      end

      bxrh_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .size      (size),
         .token_in  (tok_chain[i]),
         .token_out (tok_chain[i+1]),
         .shift_en  (shift_en),
         .shift_in  (shift_src),
         .digest    (digest[i])
      );
   end

`include "block_xor_rotate_hash_macros.svh"

   `BXRH_ASSERT_NEXT(a_finish_closes_input, clock, reset,
      req_valid && req_ready && (req_kind == KIND_FINISH), !req_ready,
      "input still open after a finish transfer")

   `BXRH_ASSERT_SAME(a_finish_exits_in_drain, clock, reset,
      tok_chain[MAX_BLOCK].valid && (tok_chain[MAX_BLOCK].finish == KIND_FINISH),
      status.draining,
      "finish left the cell chain outside the drain phase")

   `BXRH_ASSERT_NEXT(a_transfer_enters_chain, clock, reset,
      req_valid && req_ready, tok_chain[1].valid,
      "accepted transfer did not enter the cell chain")

   `BXRH_ASSERT_SAME(a_ready_only_in_run, clock, reset,
      req_ready, !status.draining && !status.emitting,
      "input ready outside the run phase")

endmodule
